FILE: rtl/dsf_pkg.sv
// Shared constants, types and helper functions for the decimal-sum checksum framer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dsf_pkg;

   // default width of the running sum
   localparam int SUM_WIDTH_DEF = 24;

   // width of one message character
   localparam int BYTE_W = 8;

   // width of digit counts and trailer positions
   localparam int CNT_W = 4;

   // width of one decimal digit
   localparam int DIG_W = 4;

   // trailer characters
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h29;
   localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

   // decimal digits needed for the largest sum of the given width
   function automatic int digits_for(input int w);
      longint v;
      int     n;
      begin
         v = (longint'(1) << w) - longint'(1);
         n = 1;
         while (v >= 10) begin
            v = v / 10;
            n = n + 1;
         end
         return n;
      end
   endfunction

   // converter status seen by the trailer sequencer
   typedef struct packed {
      logic             ready;
      logic [CNT_W-1:0] count;
      logic [DIG_W-1:0] digit;
   } conv_stat_type;

   // sequencer controls back to the converter
   typedef struct packed {
      logic shift;
      logic finish;
   } conv_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/decimal_sum_checksum_framer.sv
// Top level of the decimal-sum checksum framer: sum register, request side and output register.
// Depends on dsf_pkg, dsf_b2d and dsf_trail.
//
// Message bytes enter on req_ and leave unchanged on rsp_ at one byte per cycle while
// rsp_tready stays high; each is added to a SUM_WIDTH-bit wrapping sum. On the request
// with req_tlast set the block stops taking requests and appends the trailer
// "(n)ddd*\n", where n is the count of decimal digits and ddd the sum, most significant
// digit first; rsp_tlast marks the newline. The binary to decimal converter handles one
// sum bit per cycle; after a last byte it shifts in every sum bit, strips leading zero
// digits and hands over to the trailer sequencer, which then sends the n + 5 trailer
// characters; the sum restarts from zero for the next message.
`default_nettype none

module decimal_sum_checksum_framer #(
   parameter int SUM_WIDTH = dsf_pkg::SUM_WIDTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire  [7:0] req_tdata,   // [7:0] in_byte
   input  wire        req_tlast,   // in_last
   input  wire        req_tvalid,
   output logic       req_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_last
   output logic       rsp_tvalid,
   input  wire        rsp_tready
);

   localparam int DIGITS = dsf_pkg::digits_for(SUM_WIDTH);

   logic [SUM_WIDTH-1:0]        sum_ff, sum_in;
   logic [SUM_WIDTH-1:0]        sum_next;
   logic                        busy_ff, busy_in;
   logic                        vld_ff, vld_in;
   logic [dsf_pkg::BYTE_W-1:0]  data_ff, data_in;
   logic                        last_ff, last_in;
   logic                        out_free;
   logic                        req_acc;
   logic                        conv_start;
   logic                        take;
   logic                        ch_valid;
   logic [dsf_pkg::BYTE_W-1:0]  ch_byte;
   logic                        ch_last;
   dsf_pkg::conv_stat_type      stat;
   dsf_pkg::conv_ctl_type       ctl;

   assign out_free   = !vld_ff || rsp_tready;
   assign req_tready = !busy_ff && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign sum_next   = sum_ff + SUM_WIDTH'(req_tdata);
   assign conv_start = req_acc && req_tlast;
   assign take       = ch_valid && out_free && !req_acc;

   // decimal converter
   dsf_b2d #(
      .SUM_WIDTH (SUM_WIDTH),
      .DIGITS    (DIGITS)
   ) u_b2d (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .value (sum_next),
      .ctl   (ctl),
      .stat  (stat)
   );

   // trailer sequencer
   dsf_trail u_trail (
      .clock    (clock),
      .reset    (reset),
      .stat     (stat),
      .take     (take),
      .ctl      (ctl),
      .ch_valid (ch_valid),
      .ch_byte  (ch_byte),
      .ch_last  (ch_last)
   );

   // running sum and busy flag
   always_comb begin
      sum_in  = sum_ff;
      busy_in = busy_ff;
      if (req_acc) begin
         if (req_tlast) begin
            sum_in  = '0;
            busy_in = 1'b1;
         end else begin
            sum_in = sum_next;
         end
      end
      if (take && ch_last) begin
         busy_in = 1'b0;
      end
   end

   // output register: passthrough request or trailer character
   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      last_in = last_ff;
      priority if (req_acc) begin
         vld_in  = 1'b1;
         data_in = req_tdata;
         last_in = 1'b0;
      end else if (take) begin
         vld_in  = 1'b1;
         data_in = ch_byte;
         last_in = ch_last;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

FILE: rtl/dsf_b2d.sv
// Bit-serial binary to decimal converter with leading-zero strip, one digit shift per step.
// Depends on dsf_pkg for digit widths and the status/control structs.
`default_nettype none

module dsf_b2d #(
   parameter int SUM_WIDTH = dsf_pkg::SUM_WIDTH_DEF,
   parameter int DIGITS    = dsf_pkg::digits_for(SUM_WIDTH)
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire  [SUM_WIDTH-1:0]       value,
   input  wire  dsf_pkg::conv_ctl_type ctl,
   output dsf_pkg::conv_stat_type     stat
);

   localparam int BCD_W = DIGITS * dsf_pkg::DIG_W;
   localparam int BC_W  = $clog2(SUM_WIDTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_NORM  = 2'd2;
   localparam logic [1:0] ST_READY = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [SUM_WIDTH-1:0]        bin_ff, bin_in;
   logic [BCD_W-1:0]            bcd_ff, bcd_in;
   logic [BC_W-1:0]             bit_cnt_ff, bit_cnt_in;
   logic [dsf_pkg::CNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [BCD_W-1:0]            bcd_adj;
   logic [dsf_pkg::DIG_W-1:0]   top_digit;

   // add three to every digit of five or more before the next doubling
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*dsf_pkg::DIG_W +: dsf_pkg::DIG_W] >= 4'd5) begin
            bcd_adj[i*dsf_pkg::DIG_W +: dsf_pkg::DIG_W] =
               bcd_ff[i*dsf_pkg::DIG_W +: dsf_pkg::DIG_W] + 4'd3;
         end else begin
            bcd_adj[i*dsf_pkg::DIG_W +: dsf_pkg::DIG_W] =
               bcd_ff[i*dsf_pkg::DIG_W +: dsf_pkg::DIG_W];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_W-1 -: dsf_pkg::DIG_W];

   // conversion sequencer
   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dcnt_in    = dcnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in     = value;
               bcd_in     = '0;
               bit_cnt_in = BC_W'(SUM_WIDTH - 1);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // shift one binary bit into the decimal register
            {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
            if (bit_cnt_ff == '0) begin
               dcnt_in  = dsf_pkg::CNT_W'(DIGITS);
               state_in = ST_NORM;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_NORM: begin
            // drop one leading zero digit per cycle, keep at least one digit
            if (top_digit == '0 && dcnt_ff > 4'd1) begin
               bcd_in  = bcd_ff << dsf_pkg::DIG_W;
               dcnt_in = dcnt_ff - 1'b1;
            end else begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            if (ctl.finish) begin
               state_in = ST_IDLE;
            end else if (ctl.shift) begin
               bcd_in = bcd_ff << dsf_pkg::DIG_W;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dcnt_ff    <= dcnt_in;
   end

   assign stat.ready = (state_ff == ST_READY);
   assign stat.count = dcnt_ff;
   assign stat.digit = top_digit;

endmodule

`default_nettype wire

FILE: rtl/dsf_trail.sv
// Trailer sequencer: walks the checksum trailer one character per take.
// Depends on dsf_pkg for character codes and the converter status/control structs.
`default_nettype none

module dsf_trail (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  dsf_pkg::conv_stat_type     stat,
   input  wire                              take,
   output dsf_pkg::conv_ctl_type            ctl,
   output logic                             ch_valid,
   output logic [dsf_pkg::BYTE_W-1:0]       ch_byte,
   output logic                             ch_last
);

   logic [dsf_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [dsf_pkg::CNT_W-1:0] star_pos;
   logic [dsf_pkg::CNT_W-1:0] nl_pos;
   logic                      is_digit;

   assign star_pos = stat.count + 4'd3;
   assign nl_pos   = stat.count + 4'd4;
   assign is_digit = (pos_ff >= 4'd3) && (pos_ff < star_pos);

   // character at the current trailer position
   always_comb begin
      priority if (pos_ff == 4'd0) begin
         ch_byte = dsf_pkg::CHAR_OPEN;
      end else if (pos_ff == 4'd1) begin
         ch_byte = dsf_pkg::CHAR_ZERO + 8'(stat.count);
      end else if (pos_ff == 4'd2) begin
         ch_byte = dsf_pkg::CHAR_CLOSE;
      end else if (is_digit) begin
         ch_byte = dsf_pkg::CHAR_ZERO + 8'(stat.digit);
      end else if (pos_ff == star_pos) begin
         ch_byte = dsf_pkg::CHAR_STAR;
      end else begin
         ch_byte = dsf_pkg::CHAR_NL;
      end
   end

   assign ch_valid   = stat.ready;
   assign ch_last    = (pos_ff == nl_pos);
   assign ctl.shift  = take && is_digit;
   assign ctl.finish = take && ch_last;

   // position advance
   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         if (ch_last) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

FILE: verif/decimal_sum_checksum_framer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for decimal_sum_checksum_framer: passthrough bytes and the
// "(n)digits*\n" trailer are predicted per request and checked per response.
// Depends on dsf_pkg and the framer RTL.

module decimal_sum_checksum_framer_tb;

   localparam int SUM_WIDTH     = dsf_pkg::SUM_WIDTH_DEF;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_BYTES  = 480;
   localparam int REPORT_LIMIT  = 10;

   // one character of the framed stream
   typedef struct packed {
      logic [7:0] chr;
      logic       tail;
   } frame_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       req_tvalid = 1'b0;
   wire        req_tready;
   wire  [7:0] rsp_tdata;
   wire        rsp_tlast;
   wire        rsp_tvalid;
   logic       rsp_tready = 1'b0;

   frame_char_type       pending_q[$];     // message bytes still to send, tail = last flag
   frame_char_type       frame_chars_q[$]; // framed characters still to arrive
   logic [SUM_WIDTH-1:0] msg_sum = '0;
   int                   req_total = 0;
   int                   req_accepted = 0;
   int                   msg_count = 0;
   int                   chars_checked = 0;
   int                   widest_sum = 0;
   int                   mismatches = 0;
   int                   idle_cycles = 0;
   logic                 calm;

   decimal_sum_checksum_framer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // no idling on either side for a stretch of the random traffic
   assign calm = (req_accepted >= 300) && (req_accepted < 450);

   // expected framed output for one accepted request
   function automatic void frame_request(input logic [7:0] chr, input logic tail);
      int     digs[10];
      int     n;
      longint v;
      frame_chars_q.push_back(frame_char_type'{chr, 1'b0});
      msg_sum = msg_sum + SUM_WIDTH'(chr);
      if (tail) begin
         v = longint'(msg_sum);
         n = 0;
         do begin
            digs[n] = int'(v % 10);
            v = v / 10;
            n++;
         end while (v != 0);
         frame_chars_q.push_back(frame_char_type'{dsf_pkg::CHAR_OPEN, 1'b0});
         frame_chars_q.push_back(frame_char_type'{8'(dsf_pkg::CHAR_ZERO + n), 1'b0});
         frame_chars_q.push_back(frame_char_type'{dsf_pkg::CHAR_CLOSE, 1'b0});
         for (int i = n - 1; i >= 0; i--) begin
            frame_chars_q.push_back(frame_char_type'{8'(dsf_pkg::CHAR_ZERO + digs[i]), 1'b0});
         end
         frame_chars_q.push_back(frame_char_type'{dsf_pkg::CHAR_STAR, 1'b0});
         frame_chars_q.push_back(frame_char_type'{dsf_pkg::CHAR_NL, 1'b1});
         if (n > widest_sum) widest_sum = n;
         msg_sum = '0;
      end
   endfunction

   task automatic queue_byte(input logic [7:0] chr, input logic tail);
      pending_q.push_back(frame_char_type'{chr, tail});
      req_total++;
   endtask

   // random message byte, with the extremes favored
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 8'h00;
      if (r < 16) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tlast  <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_request(req_tdata, req_tlast);
            req_accepted <= req_accepted + 1;
            if (req_tlast) msg_count <= msg_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
               req_tdata  <= pending_q[0].chr;
               req_tlast  <= pending_q[0].tail;
               req_tvalid <= 1'b1;
               void'(pending_q.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      frame_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 25);
         if (rsp_tvalid && rsp_tready) begin
            if (frame_chars_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response: byte %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = frame_chars_q.pop_front();
               chars_checked++;
               if (rsp_tdata !== want.chr || rsp_tlast !== want.tail) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("response %0d: expected byte %h last %b, got byte %h last %b",
                              chars_checked, want.chr, want.tail, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      int len;
      int r;

      // single-byte messages: zero sum, one, two and three digits
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h09, 1'b1);
      queue_byte(8'h0A, 1'b1);
      queue_byte(8'hFF, 1'b1);
      // walking one, first byte counted
      for (int i = 0; i < 8; i++) queue_byte(8'(1 << i), i == 7);
      // four digits
      for (int i = 0; i < 4; i++) queue_byte(8'hFF, i == 3);
      // trailing zeros in the digit string, then 255 from two bytes
      queue_byte(8'h63, 1'b0);
      queue_byte(8'h01, 1'b1);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b1);

      // random messages, mostly short, a few long enough for five digits
      while (req_total < 20 + RANDOM_BYTES) begin
         r = $urandom_range(99);
         if (r < 85) len = $urandom_range(12, 1);
         else if (r < 95) len = $urandom_range(40, 13);
         else len = $urandom_range(200, 100);
         for (int i = 0; i < len; i++) queue_byte(pick_byte(), i == len - 1);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted != req_total) @(posedge clock);
      while (frame_chars_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("%0d messages, %0d request bytes, %0d framed characters checked",
               msg_count, req_accepted, chars_checked);
      $display("widest checksum %0d digits, %0d mismatches", widest_sum, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
